### hdl/rdif_pkg.sv
// Shared constants and types for the ring duplicate ID filter.
// No dependencies.
`default_nettype none

package rdif_pkg;

  localparam int unsigned DEFAULT_CACHE_DEPTH = 64;
  localparam int unsigned ID_HALF_W = 64;
  localparam int unsigned OP_W = 2;

  // op codes; the unused code behaves as a plain query
  localparam logic [OP_W-1:0] OP_QUERY        = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT       = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY_INSERT = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

### hdl/ring_duplicate_id_filter.sv
// Ring duplicate ID filter: ID ring memory, scan sequencer and one shared comparator.
// Depends on rdif_pkg.
`default_nettype none

// Duplicate filter for 128-bit message IDs. The block keeps the last
// CACHE_DEPTH IDs in a ring. A word is taken when start is high and busy is
// low. Op 1 (insert) writes the ID into the oldest slot and answers found=0
// in the next cycle; busy never rises for it. Op 0 and op 3 (query) and op 2
// (query, then insert on a miss) walk the valid entries with one 128-bit
// comparator, one entry per cycle through the registered read port of the ID
// memory. On a query busy stays high until every valid entry has been compared
// (all CACHE_DEPTH once the ring has wrapped, none with an empty ring), and
// the answer comes in the first cycle with busy low. The walk stops early on a
// hit, with the answer registered from the comparator once the matching entry
// is on the read port. The answer is on found, marked by done, which is high for a single cycle; the receiver
// cannot stall it, so it must take every word as it appears. The insert of
// op 2 happens at the same edge the answer is registered, so the next word
// may start in the cycle done is high.
module ring_duplicate_id_filter
  import rdif_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OP_W-1:0]      op,
  input  wire logic [ID_HALF_W-1:0] id_high,
  input  wire logic [ID_HALF_W-1:0] id_low,
  output logic                      done,
  output logic                      found
);

  localparam int unsigned ADDR_W = $clog2(CACHE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned KEY_W  = 2 * ID_HALF_W;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CACHE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_LEN  = CNT_W'(CACHE_DEPTH);

  // ID store: {upper, lower} per slot, one write and one registered read port
  logic [KEY_W-1:0] mem [CACHE_DEPTH];
  logic [KEY_W-1:0] rd_data;

  // sequencer state
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;        // next entry to read
  logic [CNT_W-1:0] scan_len, scan_len_next; // valid entries at start
  logic             pend, pend_next;      // rd_data holds a fresh entry
  logic [KEY_W-1:0] key, key_next;
  logic             ins_miss, ins_miss_next;

  // ring pointer
  logic [ADDR_W-1:0] wp, wp_next;
  logic              wrapped, wrapped_next;

  logic done_next, found_next;

  // memory port controls
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [KEY_W-1:0]  wr_data;

  logic hit;
  logic scan_end;

  assign busy = (state != ST_IDLE);

  // the shared comparator
  assign hit      = pend && (rd_data == key);
  assign scan_end = hit || (!pend && (cnt == scan_len));

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    scan_len_next = scan_len;
    pend_next     = 1'b0;
    key_next      = key;
    ins_miss_next = ins_miss;
    done_next     = 1'b0;
    found_next    = found;
    rd_en         = 1'b0;
    rd_addr       = cnt[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_data       = key;

    case (state)
      ST_IDLE: begin
        if (start) begin
          key_next = {id_high, id_low};
          if (op == OP_INSERT) begin
            // plain insert, even if already present
            wr_en      = 1'b1;
            wr_data    = {id_high, id_low};
            done_next  = 1'b1;
            found_next = 1'b0;
          end else begin
            ins_miss_next = (op == OP_QUERY_INSERT);
            scan_len_next = wrapped ? FULL_LEN : CNT_W'(wp);
            cnt_next      = '0;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          done_next  = 1'b1;
          found_next = hit;
          wr_en      = ins_miss && !hit;
          state_next = ST_IDLE;
        end else if (cnt != scan_len) begin
          rd_en     = 1'b1;
          pend_next = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ring pointer advance on every write
  always_comb begin
    wp_next      = wp;
    wrapped_next = wrapped;
    if (wr_en) begin
      if (wp == LAST_SLOT) begin
        wp_next      = '0;
        wrapped_next = 1'b1;
      end else begin
        wp_next = wp + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pend    <= 1'b0;
      done    <= 1'b0;
      wp      <= '0;
      wrapped <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= pend_next;
      done    <= done_next;
      wp      <= wp_next;
      wrapped <= wrapped_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    scan_len <= scan_len_next;
    key      <= key_next;
    ins_miss <= ins_miss_next;
    found    <= found_next;
  end

`ifndef SYNTHESIS
  // a hit can only come out of a scan
  a_found_from_scan: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> ($past(state) == ST_SCAN))
    else $error("found raised without a scan");

  // the answer comes with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("done while still scanning");

  // the walk never runs past the valid entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= scan_len))
    else $error("scan counter beyond valid entries");

  // once the ring has wrapped, every entry stays valid
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrapped flag cleared");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for ring_duplicate_id_filter: drives query and insert words and
// checks every found answer against a built-in model of the 64-entry ID ring.
// Depends on rdif_pkg and the ring_duplicate_id_filter RTL.
module testbench;
  import rdif_pkg::*;

  localparam int unsigned CACHE_DEPTH = DEFAULT_CACHE_DEPTH;
  // op 3 has no name in the package; the block treats it as a plain query
  localparam logic [OP_W-1:0] OP_SPARE_QUERY = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned RECENT_KEEP = 96;

  typedef logic [ID_HALF_W-1:0] half_t;

  // one answer still owed by the block, with the word that caused it
  typedef struct {
    logic [OP_W-1:0] op;
    half_t           hi;
    half_t           lo;
    logic            found;
  } answer_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [OP_W-1:0] op;
  half_t           id_high;
  half_t           id_low;
  logic            done;
  logic            found;

  // model of the ring: ID halves, next slot and the wrapped flag
  half_t                          ring_hi [CACHE_DEPTH];
  half_t                          ring_lo [CACHE_DEPTH];
  logic [$clog2(CACHE_DEPTH)-1:0] ring_ptr;
  logic                           ring_full;

  answer_t        pending_answers[$];
  logic [127:0]   recent_ids[$];   // IDs sent with an insert op, newest last
  int unsigned    mismatch_count;

  ring_duplicate_id_filter #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .id_high(id_high),
    .id_low (id_low),
    .done   (done),
    .found  (found)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------

  // Compare against the valid slots only: all of them once the ring wrapped,
  // else the ones below the write pointer. Unwritten slots are never touched.
  function automatic logic id_in_ring(input half_t hi, input half_t lo);
    int unsigned valid;
    valid = ring_full ? CACHE_DEPTH : int'(ring_ptr);
    for (int unsigned i = 0; i < valid; i++) begin
      if (ring_hi[i] == hi && ring_lo[i] == lo) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Overwrite the oldest slot; the pointer wraps naturally at its width.
  function automatic void ring_insert(input half_t hi, input half_t lo);
    ring_hi[ring_ptr] = hi;
    ring_lo[ring_ptr] = lo;
    ring_ptr = ring_ptr + 1'b1;
    if (ring_ptr == '0) ring_full = 1'b1;
  endfunction

  // Expected found bit for one word; updates the model as the block would.
  function automatic logic lookup_and_update(input logic [OP_W-1:0] op_i,
                                             input half_t hi, input half_t lo);
    logic hit;
    if (op_i == OP_INSERT) begin
      // duplicates are inserted too; answer is always 0
      ring_insert(hi, lo);
      return 1'b0;
    end
    hit = id_in_ring(hi, lo);
    if (op_i == OP_QUERY_INSERT && !hit) ring_insert(hi, lo);
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------

  // Present one word at the falling edge and hold it until an edge with busy
  // low takes it. Start is left high so the next word can follow directly.
  task automatic send_word(input logic [OP_W-1:0] op_i, input half_t hi, input half_t lo);
    answer_t a;
    @(negedge clk);
    start   <= 1'b1;
    op      <= op_i;
    id_high <= hi;
    id_low  <= lo;
    do @(posedge clk); while (busy);
    a.op    = op_i;
    a.hi    = hi;
    a.lo    = lo;
    a.found = lookup_and_update(op_i, hi, lo);
    pending_answers.push_back(a);
    if (op_i == OP_INSERT || op_i == OP_QUERY_INSERT) begin
      recent_ids.push_back({hi, lo});
      if (recent_ids.size() > RECENT_KEEP) void'(recent_ids.pop_front());
    end
  endtask

  // Sender gap: mostly none or short, now and then long.
  task automatic sender_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 88) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 80);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic half_t rand_half();
    return {$urandom(), $urandom()};
  endfunction

  // ID mix: fresh random, a recent one (live or already evicted), a near miss
  // of a recent one (one bit flipped), or an extreme pattern.
  function automatic logic [127:0] pick_id();
    int unsigned pick;
    logic [127:0] id;
    pick = $urandom_range(0, 99);
    if (recent_ids.size() == 0 || pick < 40) begin
      id = {rand_half(), rand_half()};
    end else if (pick < 80) begin
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end else if (pick < 92) begin
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      id[$urandom_range(0, 127)] ^= 1'b1;
    end else begin
      case ($urandom_range(0, 3))
        0: id = '0;
        1: id = '1;
        2: id = {{ID_HALF_W{1'b1}}, {ID_HALF_W{1'b0}}};
        default: id = {{ID_HALF_W{1'b0}}, {ID_HALF_W{1'b1}}};
      endcase
    end
    return id;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return OP_QUERY_INSERT;
    if (pick < 60) return OP_QUERY;
    if (pick < 88) return OP_INSERT;
    return OP_SPARE_QUERY;
  endfunction

  // ---------------------------------------------------------------------------
  // Answer checker: every done must match the oldest owed answer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected answer: found=%b with nothing pending", $time, found);
      end else begin
        a = pending_answers.pop_front();
        if (found !== a.found) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] found mismatch: op=%0d id=%h_%h expected %b got %b",
                     $time, a.op, a.hi, a.lo, a.found, found);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every op on the edges of the ID space, on an empty and a partly filled
  // ring: half matches, duplicate inserts, op 2 hit leaving the ring alone.
  task automatic test_ops_and_extremes();
    half_t ones;
    half_t zeros;
    half_t alt_a;
    half_t alt_b;
    ones  = '1;
    zeros = '0;
    alt_a = {(ID_HALF_W/2){2'b10}};
    alt_b = {(ID_HALF_W/2){2'b01}};
    send_word(OP_QUERY,        zeros, zeros);  // empty ring, nothing valid
    send_word(OP_QUERY_INSERT, zeros, zeros);  // miss -> insert
    send_word(OP_QUERY,        zeros, zeros);
    send_word(OP_QUERY_INSERT, zeros, zeros);  // hit, no second copy
    send_word(OP_SPARE_QUERY,  ones,  ones);
    send_word(OP_INSERT,       ones,  ones);
    sender_gap();
    send_word(OP_SPARE_QUERY,  ones,  ones);
    send_word(OP_INSERT,       ones,  ones);   // duplicate insert
    send_word(OP_QUERY,        ones,  zeros);  // only upper half matches
    send_word(OP_QUERY,        zeros, ones);   // only lower half matches
    send_word(OP_QUERY_INSERT, alt_a, alt_b);
    send_word(OP_QUERY,        alt_b, alt_a);
    send_word(OP_QUERY,        alt_a, alt_b);
    send_word(OP_INSERT,       {1'b1, {(ID_HALF_W-1){1'b0}}}, half_t'(1));
    send_word(OP_QUERY,        {1'b1, {(ID_HALF_W-1){1'b0}}}, half_t'(1));
    send_word(OP_QUERY,        {1'b1, {(ID_HALF_W-1){1'b0}}}, half_t'(0));
    sender_gap();
    send_word(OP_QUERY_INSERT, ones,  ones);   // hit on an early slot, no second copy
  endtask

  // Fill past the end of the ring back to back, then probe for the directed IDs
  // that were overwritten and for IDs built from the halves of recent ones.
  task automatic test_ring_wrap();
    for (int unsigned i = 0; i < CACHE_DEPTH + 8; i++) begin
      if (i[0]) send_word(OP_INSERT, rand_half(), rand_half());
      else send_word(OP_QUERY_INSERT, rand_half(), rand_half());
    end
    send_word(OP_QUERY, '0, '0);   // first directed ID, now evicted
    send_word(OP_QUERY, '1, '1);
    for (int unsigned i = 0; i < 16; i++) begin
      send_word(OP_QUERY, recent_ids[$urandom_range(0, recent_ids.size() - 1)][127:64],
                recent_ids[$urandom_range(0, recent_ids.size() - 1)][63:0]);
      sender_gap();
    end
  endtask

  // Mixed ops over recent and fresh IDs; some blocks run without gaps.
  task automatic test_random_traffic();
    logic [127:0]    id;
    logic [OP_W-1:0] op_i;
    logic            no_gaps;
    no_gaps = 1'b0;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      op_i = pick_op();
      id   = pick_id();
      send_word(op_i, id[127:64], id[63:0]);
      if (!no_gaps) sender_gap();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_QUERY;
    id_high        = '0;
    id_low         = '0;
    ring_ptr       = '0;
    ring_full      = 1'b0;
    mismatch_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ops_and_extremes();
    test_ring_wrap();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // a full scan plus pipeline in case a stray answer is still coming
    repeat (CACHE_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: slowest run is about 1100 words of a full scan plus a long gap.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### ring_duplicate_id_filter.f
hdl/rdif_pkg.sv
hdl/ring_duplicate_id_filter.sv
test/testbench.sv
